// ===== hw/rtl/rle_pkg.sv =====
// Shared types and constants of the run-length block encoder.
// Used by rle_front, rle_queue, rle_back and rle_block_encoder_top.
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

	// Coded image address space and the wider internal offset
	localparam int ADDR_W      = 16;
	localparam int ADDR_EXT_W  = ADDR_W + 2;
	localparam int OUT_ADDR_W  = 16;
	localparam int OUT_LEN_W   = 16;

	// Block size limit and the count field that holds it
	localparam int MAX_BLOCK   = 127;
	localparam int LEN_W       = $clog2(MAX_BLOCK + 1);

	// Configuration port
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	// Write queue between front and back (depth is a power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Image header
	localparam int HDR_BYTES   = 6;
	localparam int HDR_IDX_W   = $clog2(HDR_BYTES);

	localparam logic [ADDR_EXT_W-1:0] ADDR_LIMIT = ADDR_EXT_W'(1) << ADDR_W;
	localparam logic [ADDR_EXT_W-1:0] ADDR_CAP   = ADDR_LIMIT + ADDR_EXT_W'(256);
	localparam logic [ADDR_EXT_W-1:0] BODY_START = ADDR_EXT_W'(HDR_BYTES);

	localparam logic [7:0] RUN_FLAG   = 8'h80;
	localparam logic [7:0] HDR_CHAR_C = 8'h43;
	localparam logic [7:0] HDR_CHAR_P = 8'h50;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT_ONLY   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_EMPTY,
		PH_ONE,
		PH_RUN,
		PH_LIT
	} phase_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_MAIN,
		FS_CAP,
		FS_CLOSE,
		FS_PAD,
		FS_END
	} front_state_t;

	typedef enum logic {
		OP_WRITE,
		OP_END
	} op_kind_t;

	// One request from front to back: a body write, or end of image with final offset
	typedef struct packed {
		op_kind_t               kind;
		logic [ADDR_EXT_W-1:0]  addr;
		logic [7:0]             data;
	} op_t;

	// One result item
	typedef struct packed {
		logic [OUT_ADDR_W-1:0]  addr;
		logic [7:0]             data;
		logic                   wvalid;
		logic [OUT_LEN_W-1:0]   length;
		logic                   ovf;
		logic                   last;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rle_front.sv =====
// Front of the encoder: takes raw bytes, tracks the open block and issues
// body write and end-of-image requests. Depends on rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rle_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  logic [7:0]    item_byte,
	input  logic          item_eoi,
	output logic          op_push,
	output rle_pkg::op_t  op,
	input  logic          queue_full
);
	import rle_pkg::*;

	function automatic logic [ADDR_EXT_W-1:0] clamp_addr(input logic [ADDR_EXT_W-1:0] a);
		clamp_addr = (a > ADDR_CAP) ? ADDR_CAP : a;
	endfunction

	front_state_t           state_q, state_d, step_next;
	logic [7:0]             byte_q;
	logic                   eoi_q;
	phase_t                 phase_q, phase_d;
	logic [7:0]             run_byte_q, run_byte_d;
	logic [LEN_W-1:0]       len_q, len_d;
	logic [ADDR_EXT_W-1:0]  addr_q, addr_d;

	logic                   go, fin, accept;
	logic                   x_match, close_first, cap_hit;
	logic [7:0]             close_hdr;
	logic [ADDR_EXT_W-1:0]  close_addr;
	phase_t                 step_phase;
	logic [LEN_W-1:0]       step_len, len_inc;
	logic [7:0]             step_run_byte;
	logic                   step_en;
	logic [ADDR_EXT_W-1:0]  step_addr;

	assign go         = (state_q != FS_IDLE) && !queue_full;
	assign item_ready = (state_q == FS_IDLE) || fin;
	assign accept     = item_valid && item_ready;

	assign x_match = (byte_q == run_byte_q);
	assign len_inc = len_q + LEN_W'(1);

	// A run broken by a new byte or a literal hit by a repeat closes before the byte opens
	assign close_first = ((phase_q == PH_RUN) && !x_match) || ((phase_q == PH_LIT) && x_match);

	// Header byte and next block offset when the open block closes
	always_comb begin
		close_hdr = {1'b0, len_q};
		if (phase_q == PH_RUN) begin
			close_hdr  = RUN_FLAG | {1'b0, len_q};
			close_addr = clamp_addr(addr_q + ADDR_EXT_W'(2));
		end else begin
			close_addr = clamp_addr(addr_q + ADDR_EXT_W'(len_q) + ADDR_EXT_W'(1));
		end
	end

	// Classify the byte against the open block
	always_comb begin
		step_phase    = phase_q;
		step_len      = len_q;
		step_run_byte = run_byte_q;
		step_en       = 1'b0;
		step_addr     = addr_q + ADDR_EXT_W'(1);
		unique case (phase_q)
			PH_EMPTY: begin
				step_phase    = PH_ONE;
				step_len      = LEN_W'(1);
				step_run_byte = byte_q;
				step_en       = 1'b1;
			end
			PH_ONE: begin
				step_len = LEN_W'(2);
				if (x_match) begin
					step_phase = PH_RUN;
				end else begin
					step_phase    = PH_LIT;
					step_run_byte = byte_q;
					step_en       = 1'b1;
					step_addr     = addr_q + ADDR_EXT_W'(2);
				end
			end
			PH_RUN: begin
				step_len = len_inc;
			end
			PH_LIT: begin
				step_len      = len_inc;
				step_run_byte = byte_q;
				step_en       = 1'b1;
				step_addr     = addr_q + ADDR_EXT_W'(1) + ADDR_EXT_W'(len_q);
			end
		endcase
	end

	assign cap_hit = ((step_phase == PH_RUN) || (step_phase == PH_LIT))
		&& (step_len >= LEN_W'(MAX_BLOCK));

	// Step sequence of one byte
	always_comb begin
		fin       = 1'b0;
		step_next = state_q;
		if (go) begin
			unique case (state_q)
				FS_IDLE: begin
				end
				FS_MAIN: begin
					if (close_first) begin
						step_next = FS_MAIN;
					end else if (cap_hit) begin
						step_next = FS_CAP;
					end else if (eoi_q) begin
						step_next = FS_CLOSE;
					end else begin
						fin = 1'b1;
					end
				end
				FS_CAP: begin
					if (eoi_q) begin
						step_next = FS_CLOSE;
					end else begin
						fin = 1'b1;
					end
				end
				FS_CLOSE: step_next = FS_PAD;
				FS_PAD:   step_next = FS_END;
				FS_END:   fin = 1'b1;
			endcase
		end
	end

	// Next state: a new byte enters as the last step of the current one ends
	always_comb begin
		if (accept) begin
			state_d = FS_MAIN;
		end else if (fin) begin
			state_d = FS_IDLE;
		end else begin
			state_d = step_next;
		end
	end

	// Requests and block state updates
	always_comb begin
		op_push    = 1'b0;
		op.kind    = OP_WRITE;
		op.addr    = addr_q;
		op.data    = 8'd0;
		phase_d    = phase_q;
		run_byte_d = run_byte_q;
		len_d      = len_q;
		addr_d     = addr_q;
		if (go) begin
			unique case (state_q)
				FS_IDLE: begin
				end
				FS_MAIN: begin
					if (close_first) begin
						op_push = 1'b1;
						op.data = close_hdr;
						phase_d = PH_EMPTY;
						len_d   = '0;
						addr_d  = close_addr;
					end else begin
						op_push    = step_en;
						op.addr    = step_addr;
						op.data    = byte_q;
						phase_d    = step_phase;
						len_d      = step_len;
						run_byte_d = step_run_byte;
					end
				end
				FS_CAP, FS_CLOSE: begin
					if (phase_q != PH_EMPTY) begin
						op_push = 1'b1;
						op.data = close_hdr;
						phase_d = PH_EMPTY;
						len_d   = '0;
						addr_d  = close_addr;
					end
				end
				FS_PAD: begin
					// pad the body to an even size
					if (addr_q[0]) begin
						op_push = 1'b1;
						addr_d  = clamp_addr(addr_q + ADDR_EXT_W'(1));
					end
				end
				FS_END: begin
					op_push    = 1'b1;
					op.kind    = OP_END;
					phase_d    = PH_EMPTY;
					run_byte_d = 8'd0;
					len_d      = '0;
					addr_d     = BODY_START;
				end
			endcase
		end
	end

	// Hold control and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FS_IDLE;
			phase_q    <= PH_EMPTY;
			run_byte_q <= 8'd0;
			len_q      <= '0;
			addr_q     <= BODY_START;
		end else begin
			state_q    <= state_d;
			phase_q    <= phase_d;
			run_byte_q <= run_byte_d;
			len_q      <= len_d;
			addr_q     <= addr_d;
		end
	end

	// Capture the accepted byte
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= item_byte;
			eoi_q  <= item_eoi;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_queue.sv =====
// Short request queue that decouples the encoder front from its back.
// Depends on rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rle_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rle_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output rle_pkg::op_t  head,
	output logic          head_valid
);
	import rle_pkg::*;

	op_t                     slot_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;
	logic                    do_wr, do_rd;

	assign full       = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_wr      = push && !full;
	assign do_rd      = pop && head_valid;

	// Advance pointers and fill count; pointers wrap at the power-of-two depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the pushed request
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_back.sv =====
// Back of the encoder: turns queued requests into result items, drops writes
// beyond the address space, and writes the image header. Depends on rle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rle_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                count_only,
	input  logic [rle_pkg::CFG_DATA_W-1:0]      image_width,
	input  logic [rle_pkg::CFG_DATA_W-1:0]      image_height,
	input  rle_pkg::op_t                        head,
	input  logic                                head_valid,
	output logic                                pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output rle_pkg::result_t                    res
);
	import rle_pkg::*;

	logic                   res_valid_q;
	result_t                res_q, res_d;
	logic                   ovf_q, ovf_d;
	logic [HDR_IDX_W-1:0]   hdr_idx_q, hdr_idx_d;

	logic                   out_free, go, load;
	logic                   addr_over, final_ovf, hdr_last;
	logic [ADDR_W-1:0]      final_len;
	logic [7:0]             hdr_byte;

	assign out_free  = !res_valid_q || res_ready;
	assign go        = head_valid && out_free;
	assign addr_over = (head.addr >= ADDR_LIMIT);
	assign final_ovf = ovf_q || addr_over;
	assign final_len = addr_over ? {ADDR_W{1'b1}} : head.addr[ADDR_W-1:0];
	assign hdr_last  = (hdr_idx_q == HDR_IDX_W'(HDR_BYTES - 1));

	// Image header bytes: tag, then width and height little-endian
	always_comb begin
		unique case (hdr_idx_q)
			HDR_IDX_W'(0): hdr_byte = HDR_CHAR_C;
			HDR_IDX_W'(1): hdr_byte = HDR_CHAR_P;
			HDR_IDX_W'(2): hdr_byte = image_width[7:0];
			HDR_IDX_W'(3): hdr_byte = image_width[15:8];
			HDR_IDX_W'(4): hdr_byte = image_height[7:0];
			HDR_IDX_W'(5): hdr_byte = image_height[15:8];
			default:       hdr_byte = 8'd0;
		endcase
	end

	// Execute the head request
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		res_d     = '0;
		ovf_d     = ovf_q;
		hdr_idx_d = hdr_idx_q;
		if (go) begin
			unique case (head.kind)
				OP_WRITE: begin
					pop = 1'b1;
					if (addr_over) begin
						ovf_d = 1'b1;
					end else if (!count_only) begin
						load         = 1'b1;
						res_d.addr   = OUT_ADDR_W'(head.addr[ADDR_W-1:0]);
						res_d.data   = head.data;
						res_d.wvalid = 1'b1;
						res_d.ovf    = ovf_q;
					end
				end
				OP_END: begin
					load = 1'b1;
					if (count_only) begin
						pop          = 1'b1;
						res_d.length = OUT_LEN_W'(final_len);
						res_d.ovf    = final_ovf;
						res_d.last   = 1'b1;
						ovf_d        = 1'b0;
						hdr_idx_d    = '0;
					end else begin
						res_d.addr   = OUT_ADDR_W'(hdr_idx_q);
						res_d.data   = hdr_byte;
						res_d.wvalid = 1'b1;
						res_d.ovf    = ovf_q;
						if (hdr_last) begin
							pop          = 1'b1;
							res_d.length = OUT_LEN_W'(final_len);
							res_d.ovf    = final_ovf;
							res_d.last   = 1'b1;
							ovf_d        = 1'b0;
							hdr_idx_d    = '0;
						end else begin
							hdr_idx_d = hdr_idx_q + HDR_IDX_W'(1);
						end
					end
				end
			endcase
		end
	end

	// Hold the result until taken; keep overflow and header position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			ovf_q       <= 1'b0;
			hdr_idx_q   <= '0;
		end else begin
			if (out_free) begin
				res_valid_q <= load;
			end
			ovf_q     <= ovf_d;
			hdr_idx_q <= hdr_idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rle_block_encoder_top.sv =====
// Throughput: 1 byte per cycle inside a run or literal while the queue is not full; a byte
//   that closes a block and opens the next, or brings a block to 127 bytes, also takes a
//   header-write step. The final byte adds the front steps close, pad and end, and 6 header
//   results (1 in count-only mode), one result per cycle while the master side is ready.
// Reset: clears the control and configuration registers to zero and the block state to empty at body offset 6.
`timescale 1ns / 1ps
`default_nettype none

module rle_block_encoder_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [rle_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rle_pkg::CFG_DATA_W-1:0]      cfg_data,
	// raw bytes
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] data_byte
	input  logic                                s_tlast,   // end_of_image
	// coded writes
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [47:0]                         m_tdata,   // [15:0] write_addr, [23:16] write_byte,
	                                                       // [39:24] encoded_length, [40] overflow
	output logic                                m_tuser,   // write_valid
	output logic                                m_tlast    // last
);
	import rle_pkg::*;

	logic                   count_only_q;
	logic [CFG_DATA_W-1:0]  image_width_q, image_height_q;

	op_t                    front_op, queue_head;
	logic                   op_push, queue_full, queue_valid, queue_pop;
	result_t                res;

	// Store configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q   <= 1'b0;
			image_width_q  <= '0;
			image_height_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COUNT_ONLY:   count_only_q   <= cfg_data[0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (s_tvalid),
		.item_ready (s_tready),
		.item_byte  (s_tdata),
		.item_eoi   (s_tlast),
		.op_push    (op_push),
		.op         (front_op),
		.queue_full (queue_full)
	);

	rle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (op_push),
		.push_op    (front_op),
		.full       (queue_full),
		.pop        (queue_pop),
		.head       (queue_head),
		.head_valid (queue_valid)
	);

	rle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.count_only   (count_only_q),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.head         (queue_head),
		.head_valid   (queue_valid),
		.pop          (queue_pop),
		.res_valid    (m_tvalid),
		.res_ready    (m_tready),
		.res          (res)
	);

	// Pack the result onto the master side
	assign m_tdata = {7'd0, res.ovf, res.length, res.data, res.addr};
	assign m_tuser = res.wvalid;
	assign m_tlast = res.last;

`ifndef SYNTHESIS
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without a write is not the last of the image");

	a_length_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[39:24] == 16'd0)
		else $error("encoded length shown before the last result");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		op_push |-> !queue_full)
		else $error("front pushed a request into a full queue");
`endif

endmodule

`default_nettype wire
